// ----- src/tce_pkg.sv -----
// Shared types, constants and command codes for the text console engine.
package tce_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
    localparam int CELL_W      = $clog2(CELL_COUNT + 1);
    localparam int LAST_BASE   = (SCREEN_ROWS - 1) * SCREEN_COLS;

    // Field widths
    localparam int OP_W    = 3;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int HW_W    = 11;

    // Character and color constants
    localparam logic [BYTE_W-1:0] COLOR_LIMIT = 8'h90;
    localparam logic [BYTE_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
    localparam logic [BYTE_W-1:0] NL_CHAR     = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CHAR     = 8'h0D;
    localparam logic [BYTE_W-1:0] BS_CHAR     = 8'h08;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_SET   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_TEXT_COLOR = 1'b0;
    localparam logic CFG_CURSOR_OFF = 1'b1;

    // Write address select
    localparam logic [1:0] WA_CURSOR    = 2'd0;
    localparam logic [1:0] WA_CURSOR_M1 = 2'd1;
    localparam logic [1:0] WA_TARGET    = 2'd2;
    localparam logic [1:0] WA_SCAN      = 2'd3;

    // Write data select
    localparam logic [1:0] WD_ITEM  = 2'd0;
    localparam logic [1:0] WD_PRINT = 2'd1;
    localparam logic [1:0] WD_BLANK = 2'd2;
    localparam logic [1:0] WD_MOVE  = 2'd3;

    // Read address select
    localparam logic [1:0] RA_TARGET    = 2'd0;
    localparam logic [1:0] RA_SCAN      = 2'd1;
    localparam logic [1:0] RA_SCAN_NEXT = 2'd2;

    // Cursor update codes
    localparam logic [2:0] CUR_HOLD     = 3'd0;
    localparam logic [2:0] CUR_HOME     = 3'd1;
    localparam logic [2:0] CUR_COL0     = 3'd2;
    localparam logic [2:0] CUR_NEWLINE  = 3'd3;
    localparam logic [2:0] CUR_ADVANCE  = 3'd4;
    localparam logic [2:0] CUR_BACK     = 3'd5;
    localparam logic [2:0] CUR_PREV_END = 3'd6;
    localparam logic [2:0] CUR_TARGET   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
        logic [ROW_W-1:0]  target_row;
        logic [COL_W-1:0]  target_col;
        logic [BYTE_W-1:0] cell_color;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_char;
        logic              status;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [HW_W-1:0]   hw_cursor_pos;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic       latch_item;
        logic       we_char;
        logic       we_attr;
        logic [1:0] wr_addr_sel;
        logic [1:0] wr_data_sel;
        logic       re;
        logic [1:0] rd_addr_sel;
        logic [2:0] cur_op;
        logic       scan_clr;
        logic       scan_inc;
        logic       status_set;
        logic       rd_capture;
        logic       out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_nl;
        logic            is_cr;
        logic            is_bs;
        logic            col_zero;
        logic            row_zero;
        logic            col_last;
        logic            row_last;
        logic            pos_ok;
        logic            scan_move_last;
        logic            scan_end;
    } sts_t;

endpackage

// ----- src/tce_ctrl.sv -----
// Controller state machine for the text console engine.
module tce_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  tce_pkg::sts_t sts,
    output tce_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_EXEC        = 3'd1;
    localparam logic [2:0] ST_READ_WAIT   = 3'd2;
    localparam logic [2:0] ST_SCROLL_RD   = 3'd3;
    localparam logic [2:0] ST_SCROLL_MOVE = 3'd4;
    localparam logic [2:0] ST_SCROLL_BLNK = 3'd5;
    localparam logic [2:0] ST_CLEAR       = 3'd6;
    localparam logic [2:0] ST_FINISH      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.scan_clr = 1'b1;
                state_next   = ST_FINISH;
                case (sts.op)
                    tce_pkg::OP_PUT: begin
                        if (sts.is_nl) begin
                            if (sts.row_last) begin
                                cmd.cur_op = tce_pkg::CUR_COL0;
                                state_next = ST_SCROLL_RD;
                            end else begin
                                cmd.cur_op = tce_pkg::CUR_NEWLINE;
                            end
                        end else if (sts.is_cr) begin
                            cmd.cur_op = tce_pkg::CUR_COL0;
                        end else if (sts.is_bs) begin
                            if (!(sts.col_zero && sts.row_zero)) begin
                                cmd.we_char     = 1'b1;
                                cmd.wr_addr_sel = tce_pkg::WA_CURSOR_M1;
                                cmd.wr_data_sel = tce_pkg::WD_BLANK;
                                cmd.cur_op      = sts.col_zero ? tce_pkg::CUR_PREV_END
                                                               : tce_pkg::CUR_BACK;
                            end
                        end else begin
                            cmd.we_char     = 1'b1;
                            cmd.we_attr     = 1'b1;
                            cmd.wr_addr_sel = tce_pkg::WA_CURSOR;
                            cmd.wr_data_sel = tce_pkg::WD_PRINT;
                            if (!sts.col_last) begin
                                cmd.cur_op = tce_pkg::CUR_ADVANCE;
                            end else if (sts.row_last) begin
                                cmd.cur_op = tce_pkg::CUR_COL0;
                                state_next = ST_SCROLL_RD;
                            end else begin
                                cmd.cur_op = tce_pkg::CUR_NEWLINE;
                            end
                        end
                    end
                    tce_pkg::OP_DRAW: begin
                        if (sts.pos_ok) begin
                            cmd.we_char     = 1'b1;
                            cmd.we_attr     = 1'b1;
                            cmd.wr_addr_sel = tce_pkg::WA_TARGET;
                            cmd.wr_data_sel = tce_pkg::WD_ITEM;
                        end else begin
                            cmd.status_set = 1'b1;
                        end
                    end
                    tce_pkg::OP_READ: begin
                        if (sts.pos_ok) begin
                            cmd.re          = 1'b1;
                            cmd.rd_addr_sel = tce_pkg::RA_TARGET;
                            state_next      = ST_READ_WAIT;
                        end else begin
                            cmd.status_set = 1'b1;
                        end
                    end
                    tce_pkg::OP_CLEAR: begin
                        cmd.cur_op = tce_pkg::CUR_HOME;
                        state_next = ST_CLEAR;
                    end
                    tce_pkg::OP_SET: begin
                        if (sts.pos_ok) begin
                            cmd.cur_op = tce_pkg::CUR_TARGET;
                        end else begin
                            cmd.status_set = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_READ_WAIT: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_FINISH;
            end
            // Prime the read side of the row-up copy
            ST_SCROLL_RD: begin
                cmd.re          = 1'b1;
                cmd.rd_addr_sel = tce_pkg::RA_SCAN;
                state_next      = ST_SCROLL_MOVE;
            end
            // One cell moved up per cycle, next read overlapped with this write
            ST_SCROLL_MOVE: begin
                cmd.we_char     = 1'b1;
                cmd.we_attr     = 1'b1;
                cmd.wr_addr_sel = tce_pkg::WA_SCAN;
                cmd.wr_data_sel = tce_pkg::WD_MOVE;
                cmd.scan_inc    = 1'b1;
                if (sts.scan_move_last) begin
                    state_next = ST_SCROLL_BLNK;
                end else begin
                    cmd.re          = 1'b1;
                    cmd.rd_addr_sel = tce_pkg::RA_SCAN_NEXT;
                end
            end
            // Bottom row: characters blanked, colors kept
            ST_SCROLL_BLNK: begin
                cmd.we_char     = 1'b1;
                cmd.wr_addr_sel = tce_pkg::WA_SCAN;
                cmd.wr_data_sel = tce_pkg::WD_BLANK;
                if (sts.scan_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_CLEAR: begin
                cmd.we_char     = 1'b1;
                cmd.we_attr     = 1'b1;
                cmd.wr_addr_sel = tce_pkg::WA_SCAN;
                cmd.wr_data_sel = tce_pkg::WD_BLANK;
                if (sts.scan_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/tce_datapath.sv -----
// Datapath: screen stores, cursor, scan counter, config and result registers.
module tce_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tce_pkg::in_item_t              s_data,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [tce_pkg::BYTE_W-1:0]     cfg_data,
    input  tce_pkg::cmd_t                  cmd,
    output tce_pkg::sts_t                  sts,
    output tce_pkg::out_item_t             m_data
);

    localparam int CW = tce_pkg::CELL_W;
    localparam int AW = $clog2(tce_pkg::CELL_COUNT);

    // Screen stores
    logic [tce_pkg::BYTE_W-1:0] char_mem [tce_pkg::CELL_COUNT];
    logic [tce_pkg::BYTE_W-1:0] attr_mem [tce_pkg::CELL_COUNT];
    logic [tce_pkg::BYTE_W-1:0] char_rd_reg;
    logic [tce_pkg::BYTE_W-1:0] attr_rd_reg;

    tce_pkg::in_item_t          item_reg;
    tce_pkg::out_item_t         out_reg;
    logic [tce_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tce_pkg::COL_W-1:0]  col_reg, col_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic                       status_reg, status_next;
    logic [tce_pkg::BYTE_W-1:0] rd_char_reg, rd_char_next;
    logic [tce_pkg::BYTE_W-1:0] text_color_reg;
    logic                       cursor_off_reg;

    logic [CW-1:0]              cursor_idx;
    logic [CW-1:0]              target_idx;
    logic [CW-1:0]              wr_addr;
    logic [CW-1:0]              rd_addr;
    logic [tce_pkg::BYTE_W-1:0] wr_char;
    logic [tce_pkg::BYTE_W-1:0] wr_attr;

    // Cell indexes
    assign cursor_idx = CW'(row_reg) * CW'(tce_pkg::SCREEN_COLS) + CW'(col_reg);
    assign target_idx = CW'(item_reg.target_row) * CW'(tce_pkg::SCREEN_COLS)
                      + CW'(item_reg.target_col);

    // Status toward the controller
    always_comb begin
        sts.op             = item_reg.operation;
        sts.is_nl          = (item_reg.data_byte == tce_pkg::NL_CHAR);
        sts.is_cr          = (item_reg.data_byte == tce_pkg::CR_CHAR);
        sts.is_bs          = (item_reg.data_byte == tce_pkg::BS_CHAR);
        sts.col_zero       = (col_reg == '0);
        sts.row_zero       = (row_reg == '0);
        sts.col_last       = (col_reg == tce_pkg::COL_W'(tce_pkg::SCREEN_COLS - 1));
        sts.row_last       = (row_reg == tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS - 1));
        sts.pos_ok         = (item_reg.target_row < tce_pkg::ROW_W'(tce_pkg::SCREEN_ROWS))
                          && (item_reg.target_col < tce_pkg::COL_W'(tce_pkg::SCREEN_COLS));
        sts.scan_move_last = (scan_reg == CW'(tce_pkg::LAST_BASE - 1));
        sts.scan_end       = (scan_reg == CW'(tce_pkg::CELL_COUNT - 1));
    end

    // Address and write data selection
    always_comb begin
        case (cmd.wr_addr_sel)
            tce_pkg::WA_CURSOR:    wr_addr = cursor_idx;
            tce_pkg::WA_CURSOR_M1: wr_addr = cursor_idx - CW'(1);
            tce_pkg::WA_TARGET:    wr_addr = target_idx;
            default:               wr_addr = scan_reg;
        endcase
        case (cmd.rd_addr_sel)
            tce_pkg::RA_TARGET:    rd_addr = target_idx;
            tce_pkg::RA_SCAN:      rd_addr = scan_reg + CW'(tce_pkg::SCREEN_COLS);
            default:               rd_addr = scan_reg + CW'(tce_pkg::SCREEN_COLS + 1);
        endcase
        case (cmd.wr_data_sel)
            tce_pkg::WD_ITEM: begin
                wr_char = item_reg.data_byte;
                wr_attr = item_reg.cell_color;
            end
            tce_pkg::WD_PRINT: begin
                wr_char = item_reg.data_byte;
                wr_attr = text_color_reg;
            end
            tce_pkg::WD_BLANK: begin
                wr_char = tce_pkg::BLANK_CHAR;
                wr_attr = text_color_reg;
            end
            default: begin
                wr_char = char_rd_reg;
                wr_attr = attr_rd_reg;
            end
        endcase
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.we_char) begin
            char_mem[wr_addr[AW-1:0]] <= wr_char;
        end
        if (cmd.we_attr) begin
            attr_mem[wr_addr[AW-1:0]] <= wr_attr;
        end
        if (cmd.re) begin
            char_rd_reg <= char_mem[rd_addr[AW-1:0]];
            attr_rd_reg <= attr_mem[rd_addr[AW-1:0]];
        end
    end

    // Cursor update
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            tce_pkg::CUR_HOME: begin
                row_next = '0;
                col_next = '0;
            end
            tce_pkg::CUR_COL0: begin
                col_next = '0;
            end
            tce_pkg::CUR_NEWLINE: begin
                row_next = row_reg + tce_pkg::ROW_W'(1);
                col_next = '0;
            end
            tce_pkg::CUR_ADVANCE: begin
                col_next = col_reg + tce_pkg::COL_W'(1);
            end
            tce_pkg::CUR_BACK: begin
                col_next = col_reg - tce_pkg::COL_W'(1);
            end
            tce_pkg::CUR_PREV_END: begin
                row_next = row_reg - tce_pkg::ROW_W'(1);
                col_next = tce_pkg::COL_W'(tce_pkg::SCREEN_COLS - 1);
            end
            tce_pkg::CUR_TARGET: begin
                row_next = item_reg.target_row;
                col_next = item_reg.target_col;
            end
            default: begin
            end
        endcase
    end

    // Scan counter and per-transaction result bits
    always_comb begin
        scan_next    = scan_reg;
        status_next  = status_reg;
        rd_char_next = rd_char_reg;
        if (cmd.scan_clr) begin
            scan_next = '0;
        end else if (cmd.scan_inc) begin
            scan_next = scan_reg + CW'(1);
        end
        if (cmd.latch_item) begin
            status_next  = 1'b0;
            rd_char_next = '0;
        end else begin
            if (cmd.status_set) begin
                status_next = 1'b1;
            end
            if (cmd.rd_capture) begin
                rd_char_next = char_rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        rd_char_reg <= rd_char_next;
        if (cmd.latch_item) begin
            item_reg <= s_data;
        end
        if (cmd.out_load) begin
            out_reg.read_char     <= rd_char_reg;
            out_reg.status        <= status_reg;
            out_reg.cur_row       <= row_reg;
            out_reg.cur_col       <= col_reg;
            out_reg.hw_cursor_pos <= cursor_off_reg
                                   ? tce_pkg::HW_W'(tce_pkg::CELL_COUNT)
                                   : tce_pkg::HW_W'(cursor_idx);
        end
    end

    // Cursor and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            text_color_reg <= tce_pkg::COLOR_RESET;
            cursor_off_reg <= 1'b0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_we) begin
                if (cfg_index == tce_pkg::CFG_TEXT_COLOR) begin
                    if (cfg_data < tce_pkg::COLOR_LIMIT) begin
                        text_color_reg <= cfg_data;
                    end
                end else begin
                    cursor_off_reg <= cfg_data[0];
                end
            end
        end
    end

    assign m_data = out_reg;

endmodule

// ----- src/text_console_engine_top.sv -----
// Text console engine: 80x25 character/attribute screen with a cursor.
// Timing: the result is registered via EXEC then FINISH after acceptance, with READ_WAIT
// between them for read cell; a scroll adds a row-up copy one cell per cycle and a bottom-row blank,
// and a clear adds a blanking pass over all 2000 cells. Throughput: one transaction at a time;
// a scroll, clear or result stall holds off the next, which is accepted the cycle after the result loads.
// Reset (aresetn, sync, active low): cursor home, color 7, cursor shown; screen undefined.
module text_console_engine_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tce_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tce_pkg::out_item_t            m_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tce_pkg::BYTE_W-1:0]    cfg_data
);

    tce_pkg::cmd_t cmd;
    tce_pkg::sts_t sts;

    tce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tce_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule
